// ----- rtl/keystroke_entropy_qualifier_assert.svh -----
// Assertion macros for the keystroke entropy qualifier.
// They expand to concurrent assertions in simulation and to nothing in synthesis.
`ifndef KEYSTROKE_ENTROPY_QUALIFIER_ASSERT_SVH
`define KEYSTROKE_ENTROPY_QUALIFIER_ASSERT_SVH

`ifndef SYNTHESIS

`define KEQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("keq: assertion failed");

`define KEQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("keq: assertion failed");

`else

`define KEQ_ASSERT(label, clk, rst_n, prop)

`define KEQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- rtl/keq_pkg.sv -----
package keq_pkg;

  localparam int unsigned EVENT_W  = 16;
  localparam int unsigned DELTA_W  = 32;
  localparam int unsigned RCOUNT_W = 3;
  localparam int unsigned WARMUP_W = 2;

  // Number of leading words that never earn credit.
  localparam logic [WARMUP_W-1:0] WARMUP_ITEMS = 2'd3;
  // Highest match count that still earns credit.
  localparam int unsigned MAX_REPEATS_OK = 1;
  // The reported match count saturates here.
  localparam int unsigned REPEAT_SAT = 7;

  typedef logic [EVENT_W-1:0]  event_t;
  typedef logic [DELTA_W-1:0]  delta_t;
  typedef logic [RCOUNT_W-1:0] rcount_t;

  // Qualification result handed from the event tracker to the top level.
  typedef struct packed {
    logic    credit;
    rcount_t repeat_count;
  } qual_t;

endpackage

// ----- rtl/keq_estimate.sv -----
module keq_estimate import keq_pkg::*; #(
  parameter int unsigned DELTA_ORDERS = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   update_i,
  input  delta_t delta_i,
  output delta_t estimate_o
);

  delta_t hist_q [DELTA_ORDERS];
  delta_t hist_d [DELTA_ORDERS];
  delta_t chain  [DELTA_ORDERS+1];
  delta_t lowest [DELTA_ORDERS+1];

  assign chain[0]  = delta_i;
  assign lowest[0] = delta_i;

  // Each step takes the absolute difference against one stored order, starting
  // from the highest index, and that stored order takes the value it was compared with.
  for (genvar j = 0; j < DELTA_ORDERS; j++) begin : g_order
    localparam int unsigned K = DELTA_ORDERS - 1 - j;

    assign hist_d[K]   = chain[j];
    assign chain[j+1]  = (chain[j] > hist_q[K]) ? (chain[j] - hist_q[K])
                                                : (hist_q[K] - chain[j]);
    assign lowest[j+1] = (chain[j+1] < lowest[j]) ? chain[j+1] : lowest[j];
  end

  assign estimate_o = lowest[DELTA_ORDERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DELTA_ORDERS; k++) begin
        hist_q[k] <= '0;
      end
    end else if (update_i) begin
      hist_q <= hist_d;
    end
  end

endmodule

// ----- rtl/keq_events.sv -----
module keq_events import keq_pkg::*; #(
  parameter int unsigned EVENT_DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   update_i,
  input  event_t event_i,
  output qual_t  qual_o
);

  localparam int unsigned CNT_W = $clog2(EVENT_DEPTH + 1);

  event_t                      hist_q [EVENT_DEPTH];
  logic [WARMUP_W-1:0]         warmup_q;
  logic [CNT_W-1:0]            hit_count;
  logic [CNT_W+RCOUNT_W-1:0]   hit_count_ext;

  always_comb begin
    hit_count = '0;
    for (int k = 0; k < EVENT_DEPTH; k++) begin
      if (hist_q[k] == event_i) begin
        hit_count = hit_count + CNT_W'(1);
      end
    end
  end

  assign hit_count_ext = (CNT_W + RCOUNT_W)'(hit_count);

  always_comb begin
    qual_o.credit = (warmup_q == '0) && (int'(hit_count) <= MAX_REPEATS_OK);
    if (int'(hit_count) > REPEAT_SAT) begin
      qual_o.repeat_count = RCOUNT_W'(REPEAT_SAT);
    end else begin
      qual_o.repeat_count = hit_count_ext[RCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < EVENT_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
      warmup_q <= WARMUP_ITEMS;
    end else if (update_i) begin
      hist_q[0] <= event_i;
      for (int k = 1; k < EVENT_DEPTH; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
      if (warmup_q != '0) begin
        warmup_q <= warmup_q - WARMUP_W'(1);
      end
    end
  end

endmodule

// ----- rtl/keystroke_entropy_qualifier.sv -----
// Keystroke entropy qualifier. Each input word carries an event code and the
// timer delta since the previous event; each produces exactly one result word
// holding a conservative estimate (the smallest of the delta and its first
// DELTA_ORDERS absolute differences), the number of the last EVENT_DEPTH events
// that share this code (saturating at seven), and a credit flag that is raised
// only once three words have passed since reset and the code has been seen at
// most once in that history. The block takes one word per clock cycle and keeps
// that rate while results are drained without stalls. A word is captured in an
// input register, evaluated in a single pass of combinational logic, and its
// result is registered in and presented from the output register. The longest
// path, and hence the clock rate, is set by the chain of DELTA_ORDERS subtract
// and compare steps in the estimate stage. The histories and the warm-up count
// advance only when a word moves into the output register, so stalls on the
// output side hold everything in place and simply push back on the input.
`include "keystroke_entropy_qualifier_assert.svh"

module keystroke_entropy_qualifier import keq_pkg::*; #(
  parameter int unsigned EVENT_DEPTH  = 4,
  parameter int unsigned DELTA_ORDERS = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  event_t  event_code_i,
  input  delta_t  timing_delta_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output delta_t  estimate_o,
  output logic    credit_o,
  output rcount_t repeat_count_o
);

  // Input register.
  logic   in_valid_q;
  event_t event_q;
  delta_t delta_q;

  // Result register.
  logic    out_valid_q;
  delta_t  estimate_q;
  logic    credit_q;
  rcount_t repeat_q;

  logic   accept;
  logic   advance;
  delta_t estimate;
  qual_t  qual;

  // A held word moves on whenever the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  keq_estimate #(
    .DELTA_ORDERS(DELTA_ORDERS)
  ) u_estimate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .update_i  (advance),
    .delta_i   (delta_q),
    .estimate_o(estimate)
  );

  keq_events #(
    .EVENT_DEPTH(EVENT_DEPTH)
  ) u_events (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .update_i(advance),
    .event_i (event_q),
    .qual_o  (qual)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_code_i;
      delta_q <= timing_delta_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      estimate_q <= estimate;
      credit_q   <= qual.credit;
      repeat_q   <= qual.repeat_count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign estimate_o     = estimate_q;
  assign credit_o       = credit_q;
  assign repeat_count_o = repeat_q;

  // Credit is only ever granted for an event seen at most once in the history.
  `KEQ_ASSERT(a_credit_needs_few_repeats, clk_i, rst_ni, (out_valid_o && credit_o) |-> (repeat_count_o <= RCOUNT_W'(MAX_REPEATS_OK)))

  // The estimate never exceeds the delta of the word that produced it.
  `KEQ_ASSERT(a_estimate_bounded, clk_i, rst_ni, advance |=> (estimate_q <= $past(delta_q)))

  // A held word that cannot move on is neither lost nor altered.
  `KEQ_ASSERT(a_held_word_kept, clk_i, rst_ni, (in_valid_q && !advance) |=> (in_valid_q && $stable(delta_q) && $stable(event_q)))

endmodule
